// ===== rtl/rfe_pkg.sv =====
package rfe_pkg;

	localparam int MAX_LEN_DEF   = 512;
	localparam int MAX_RAILS_DEF = 16;

	localparam int BYTE_W     = 8;
	localparam int RAIL_CNT_W = 5;

	localparam logic [RAIL_CNT_W-1:0] RAIL_RESET = 5'd10;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

endpackage

// ===== rtl/rfe_ram.sv =====
module rfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rail_fence_encipher_top.sv =====
// Rail fence encipherer.
// Input channel (in_valid/in_stall): operation 0 loads data_byte into the
// message buffer; end_of_message on a load closes the message. A load after
// a closed message starts a new one. Loads past MAX_LEN bytes are dropped.
// Operation 1 fetches the next cipher byte in rail order and produces one
// output transaction; loads produce none.
// Output channel (out_valid/out_stall): cipher_byte, last_of_cipher and
// exhausted. exhausted is set, with a zero byte, when nothing remains or no
// closed message exists.
// The user must write rail_count via wr_en/wr_data only while the block is
// idle (block does not enforce it); resets to 10, clamped to 2..MAX_RAILS.
// Throughput: one transaction per cycle while in_stall is low, set by the
// index update and one buffer read per fetch. The buffer is read into the
// read stage at the edge that accepts a fetch, and the result moves on into
// the output register whenever that register is empty or not stalled.
// Reset clears the message, stream position and output valid; no clearing
// pass is needed. When the receiver stalls, the result holds in the output
// register, the read stage behind it holds, and in_stall rises once both
// are full.
module rail_fence_encipher_top
	import rfe_pkg::*;
#(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MAX_RAILS = MAX_RAILS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [RAIL_CNT_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  end_of_message,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     cipher_byte,
	output logic                  last_of_cipher,
	output logic                  exhausted
);

	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int RAIL_W = (MAX_RAILS > 2) ? $clog2(MAX_RAILS) : 1;
	localparam int RC_W   = $clog2(MAX_RAILS + 1);
	localparam int STEP_W = RC_W + 1;
	localparam int SUM_W  = ((LEN_W > STEP_W) ? LEN_W : STEP_W) + 1;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [RC_W-1:0]   rc_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [ADDR_W-1:0] addr_t;

	logic [RAIL_CNT_W-1:0] rail_count_q;
	len_t                  msg_len_q;
	logic                  closed_q;
	logic [RAIL_W-1:0]     cur_rail_q;
	len_t                  rd_idx_q;
	logic                  second_q;
	len_t                  emitted_q;

	logic                  valid_s1;
	logic                  ex_s1;
	logic                  last_s1;
	logic [BYTE_W-1:0]     rd_data;

	logic accept, s1_move, is_fetch, is_load;

	assign s1_move  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;
	assign is_fetch = accept && (operation == OP_FETCH);
	assign is_load  = accept && (operation == OP_LOAD);

	// Effective rail count, clamped into 2..MAX_RAILS
	rc_t rails;
	always_comb begin
		if (rail_count_q < 2) begin
			rails = rc_t'(2);
		end else if (int'(rail_count_q) > MAX_RAILS) begin
			rails = rc_t'(MAX_RAILS);
		end else begin
			rails = rc_t'(rail_count_q);
		end
	end

	// Fetch path
	rc_t   cur;
	logic  rail_over;
	len_t  emit_eff;
	len_t  emit_inc;
	logic  fetch_ex;
	logic  fetch_last;
	step_t period, two_r, step;
	sum_t  next_idx;
	rc_t   rail_nx;
	logic  stay_on_rail, rail_ok;

	assign cur       = rc_t'(cur_rail_q);
	assign rail_over = cur >= rails;
	assign emit_eff  = (closed_q && (emitted_q < msg_len_q) && rail_over) ? msg_len_q : emitted_q;
	assign fetch_ex  = !closed_q || (emit_eff >= msg_len_q) || (rd_idx_q >= msg_len_q)
		|| (int'(rd_idx_q) >= MAX_LEN);
	assign emit_inc   = emit_eff + len_t'(1);
	assign fetch_last = (emit_inc == msg_len_q);

	assign period = {rails, 1'b0} - step_t'(2);
	assign two_r  = {cur, 1'b0};
	always_comb begin
		if ((cur == '0) || (cur + rc_t'(1) == rails)) begin
			step = period;
		end else if (second_q) begin
			step = two_r;
		end else begin
			step = period - two_r;
		end
	end

	assign next_idx     = sum_t'(rd_idx_q) + sum_t'(step);
	assign stay_on_rail = next_idx < sum_t'(msg_len_q);
	assign rail_nx      = cur + rc_t'(1);
	// a rail starting at or past the length is skipped, and so are all after it
	assign rail_ok      = (rail_nx < rails) && (sum_t'(rail_nx) < sum_t'(msg_len_q));

	// Load path
	len_t len_base;
	logic load_wr;
	assign len_base = closed_q ? '0 : msg_len_q;
	assign load_wr  = is_load && (int'(len_base) < MAX_LEN);

	rfe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_LEN)
	) u_msg_ram (
		.clk  (clk),
		.we   (load_wr),
		.waddr(addr_t'(len_base)),
		.wdata(data_byte),
		.re   (is_fetch && !fetch_ex),
		.raddr(addr_t'(rd_idx_q)),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_count_q <= RAIL_RESET;
		end else if (wr_en) begin
			rail_count_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q  <= '0;
			closed_q   <= 1'b0;
			cur_rail_q <= '0;
			rd_idx_q   <= '0;
			second_q   <= 1'b0;
			emitted_q  <= '0;
		end else if (is_load) begin
			msg_len_q <= load_wr ? len_base + len_t'(1) : len_base;
			closed_q  <= end_of_message;
			if (closed_q || end_of_message) begin
				cur_rail_q <= '0;
				rd_idx_q   <= '0;
				second_q   <= 1'b0;
				emitted_q  <= '0;
			end
		end else if (is_fetch) begin
			if (fetch_ex) begin
				emitted_q <= emit_eff;
			end else if (fetch_last) begin
				emitted_q <= emit_inc;
			end else if (stay_on_rail) begin
				emitted_q <= emit_inc;
				rd_idx_q  <= len_t'(next_idx);
				second_q  <= !second_q;
			end else if (rail_ok) begin
				emitted_q  <= emit_inc;
				cur_rail_q <= rail_nx[RAIL_W-1:0];
				rd_idx_q   <= len_t'(rail_nx);
				second_q   <= 1'b0;
			end else begin
				emitted_q <= msg_len_q;
			end
		end
	end

	// Read stage: buffer data lands alongside these flags; an empty stage
	// loads even while the output register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= is_fetch;
		end
	end

	always_ff @(posedge clk) begin
		if (is_fetch) begin
			ex_s1   <= fetch_ex;
			last_s1 <= fetch_last && !fetch_ex;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			cipher_byte    <= ex_s1 ? '0 : rd_data;
			last_of_cipher <= last_s1;
			exhausted      <= ex_s1;
		end
	end

endmodule

// ===== test/tb_rail_fence_encipher_top.sv =====
`timescale 1ns / 1ps

module tb_rail_fence_encipher_top
	import rfe_pkg::*;
();

	localparam int IDLE_PCT      = 38;
	localparam int HOLD_CYCLES   = 60;
	localparam int DRAIN_CYCLES  = 6;
	localparam int WATCHDOG      = 2000;
	localparam int RANDOM_ITEMS  = 600;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] data;
		logic              eom;
	} cipher_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cbyte;
		logic              last;
		logic              exh;
	} cipher_res_t;

	typedef struct packed {
		cipher_req_t req;
		logic        pinned;
		cipher_res_t res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [RAIL_CNT_W-1:0] wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  operation;
	logic [BYTE_W-1:0]     data_byte;
	logic                  end_of_message;
	logic                  out_valid;
	logic                  out_stall;
	logic [BYTE_W-1:0]     cipher_byte;
	logic                  last_of_cipher;
	logic                  exhausted;

	// encipher state mirror
	logic [BYTE_W-1:0]     msg_buf [0:MAX_LEN_DEF-1];
	logic [9:0]            msg_len     = '0;
	logic                  msg_closed  = 1'b0;
	logic [3:0]            rail_cur    = '0;
	logic [9:0]            rd_idx      = '0;
	logic                  second_step = 1'b0;
	logic [9:0]            emitted     = '0;
	logic [RAIL_CNT_W-1:0] rail_reg    = RAIL_RESET;

	cipher_res_t pending_cipher [$];
	dir_row_t    dir_rows [$];

	// typed expectation travelling with the current transaction
	logic        pin_on  = 1'b0;
	cipher_res_t pin_res = '0;

	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	int fail_cnt     = 0;
	int items_done   = 0;
	int loads_done   = 0;
	int fetches_done = 0;
	int results_seen = 0;
	int exh_seen     = 0;
	int last_seen    = 0;
	int rail_writes  = 0;
	int stall_cycles = 0;
	int idle_run     = 0;

	always #2 clk = ~clk;

	rail_fence_encipher_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cipher_byte    (cipher_byte),
		.last_of_cipher (last_of_cipher),
		.exhausted      (exhausted)
	);

	function automatic dir_row_t mk_row(logic op, logic [7:0] data, logic eom, logic pinned,
			logic [7:0] cb, logic lst, logic exh);
		dir_row_t r;
		r.req.op    = op;
		r.req.data  = data;
		r.req.eom   = eom;
		r.pinned    = pinned;
		r.res.cbyte = cb;
		r.res.last  = lst;
		r.res.exh   = exh;
		return r;
	endfunction

	function automatic void restart_stream();
		rail_cur    = '0;
		rd_idx      = '0;
		second_step = 1'b0;
		emitted     = '0;
	endfunction

	// move to the next zigzag position, or end the stream
	function automatic void step_zigzag(int unsigned rails);
		int unsigned period;
		int unsigned r;
		int unsigned stride;
		int unsigned nxt;
		period = 2 * rails - 2;
		r = rail_cur;
		if (r == 0 || r + 1 == rails) begin
			stride = period;
		end else if (second_step) begin
			stride = 2 * r;
		end else begin
			stride = period - 2 * r;
		end
		nxt = rd_idx + stride;
		if (nxt < msg_len) begin
			rd_idx      = nxt[9:0];
			second_step = !second_step;
			return;
		end
		r++;
		// rails that start past a short message are skipped
		while (r < rails && r >= msg_len)
			r++;
		if (r < rails) begin
			rail_cur    = r[3:0];
			rd_idx      = r[9:0];
			second_step = 1'b0;
		end else begin
			emitted = msg_len;
		end
	endfunction

	function automatic cipher_res_t encipher_step(cipher_req_t req);
		cipher_res_t res;
		int unsigned rails;
		res = '0;
		if (req.op == OP_LOAD) begin
			if (msg_closed) begin
				msg_closed = 1'b0;
				msg_len    = '0;
				restart_stream();
			end
			if (msg_len < MAX_LEN_DEF) begin
				msg_buf[msg_len] = req.data;
				msg_len++;
			end
			if (req.eom) begin
				msg_closed = 1'b1;
				restart_stream();
			end
			return res;
		end
		rails = rail_reg;
		if (rails < 2)
			rails = 2;
		if (rails > MAX_RAILS_DEF)
			rails = MAX_RAILS_DEF;
		// rail count lowered under the current rail ends the stream
		if (msg_closed && emitted < msg_len && rail_cur >= rails)
			emitted = msg_len;
		if (!msg_closed || emitted >= msg_len || rd_idx >= msg_len
				|| rd_idx >= MAX_LEN_DEF) begin
			res.exh = 1'b1;
			return res;
		end
		res.cbyte = msg_buf[rd_idx];
		emitted++;
		res.last = (emitted == msg_len);
		if (emitted < msg_len)
			step_zigzag(rails);
		return res;
	endfunction

	// scoreboard, predictor and watchdog
	always @(posedge clk) begin
		cipher_req_t req;
		cipher_res_t got;
		cipher_res_t want;
		cipher_res_t calc;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (wr_en) begin
				rail_reg = wr_data;
				rail_writes++;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				results_seen++;
				got.cbyte = cipher_byte;
				got.last  = last_of_cipher;
				got.exh   = exhausted;
				exh_seen  += got.exh;
				last_seen += got.last;
				if (pending_cipher.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t: unexpected transaction byte=%02h last=%0b exh=%0b",
							$realtime, got.cbyte, got.last, got.exh);
				end else begin
					want = pending_cipher.pop_front();
					if (want != got) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display({"%0t: cipher mismatch exp byte=%02h last=%0b exh=%0b,",
								" got byte=%02h last=%0b exh=%0b"},
								$realtime, want.cbyte, want.last, want.exh,
								got.cbyte, got.last, got.exh);
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				items_done++;
				req.op   = operation;
				req.data = data_byte;
				req.eom  = end_of_message;
				calc = encipher_step(req);
				if (req.op == OP_FETCH) begin
					fetches_done++;
					pending_cipher.push_back(pin_on ? pin_res : calc);
				end else begin
					loads_done++;
				end
			end
			if (in_stall)
				stall_cycles++;
			idle_run = moved ? 0 : idle_run + 1;
			if (idle_run >= WATCHDOG) begin
				$display("%0t: watchdog, no transaction for %0d cycles", $realtime, WATCHDOG);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic send_item(cipher_req_t req, logic pinned, cipher_res_t res);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while (!no_idle && $urandom_range(99) < IDLE_PCT);
		end
		in_valid       <= 1'b1;
		operation      <= req.op;
		data_byte      <= req.data;
		end_of_message <= req.eom;
		pin_on  = pinned;
		pin_res = res;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_fetch();
		cipher_req_t req;
		req.op   = OP_FETCH;
		req.data = BYTE_W'($urandom_range(255));
		req.eom  = 1'($urandom_range(1));
		send_item(req, 1'b0, '0);
	endtask

	task automatic send_noise();
		cipher_req_t req;
		req.op   = $urandom_range(1) ? OP_FETCH : OP_LOAD;
		req.data = BYTE_W'($urandom_range(255));
		req.eom  = ($urandom_range(3) == 0);
		send_item(req, 1'b0, '0);
	endtask

	task automatic run_message(int len, int fetch_n, bit noisy);
		cipher_req_t req;
		for (int i = 0; i < len; i++) begin
			req.op   = OP_LOAD;
			req.data = BYTE_W'($urandom_range(255));
			req.eom  = (i == len - 1);
			send_item(req, 1'b0, '0);
			if (noisy && $urandom_range(99) < 8)
				send_noise();
		end
		for (int i = 0; i < fetch_n; i++)
			send_fetch();
	endtask

	// register write only once all results are back and the pipe is drained
	task automatic write_rails(logic [RAIL_CNT_W-1:0] val);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_cipher.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		wr_en   <= 1'b1;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		int                    phase;
		int                    len;
		int                    fetch_n;
		logic [RAIL_CNT_W-1:0] rails_val;

		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_data        = '0;
		in_valid       = 1'b0;
		operation      = OP_LOAD;
		data_byte      = '0;
		end_of_message = 1'b0;

		// directed: reset rail count of 10, so short messages skip most rails
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(OP_LOAD,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(OP_LOAD,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_LOAD,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_LOAD,  8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h55, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'hAA, 1'b1, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(OP_FETCH, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(OP_LOAD,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
		dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h01, 1'b1, 1'b0));
		for (int i = 0; i < 8; i++)
			dir_rows.push_back(mk_row(OP_LOAD, 8'h80 >> i, (i == 7), 1'b0, 8'h00, 1'b0, 1'b0));
		for (int i = 0; i < 3; i++)
			dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].res);

		// random phases; a few fetches first keep a stream alive across rail changes
		phase = 0;
		while (items_done < RANDOM_ITEMS || phase <= 7) begin
			case (phase)
				0: rails_val = 5'd2;
				1: rails_val = 5'd16;
				2: rails_val = 5'd0;
				3: rails_val = 5'd1;
				4: rails_val = 5'd31;
				5: rails_val = 5'd17;
				6: rails_val = 5'd3;
				default: rails_val = RAIL_CNT_W'($urandom_range(31));
			endcase
			write_rails(rails_val);
			no_idle = (phase >= 3 && phase <= 5);
			repeat ($urandom_range(3)) send_fetch();
			if (phase == 7) begin
				// receiver holds off while fetches pile up behind it
				run_message(40, 0, 1'b0);
				hold_req = 1'b1;
				repeat (40) send_fetch();
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
				fetch_n = ($urandom_range(3) == 0) ? $urandom_range(len) : len + $urandom_range(2);
				run_message(len, fetch_n, !no_idle);
			end
			phase++;
		end
		no_idle = 1'b0;

		// overflow: bytes past capacity dropped, end flag on a dropped byte still closes
		write_rails(5'd7);
		run_message(MAX_LEN_DEF + 3, 4, 1'b0);

		in_valid <= 1'b0;
		while (pending_cipher.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		fail_cnt += pending_cipher.size();

		$display("covered %0d transactions in (%0d loads, %0d fetches) over %0d rail settings",
			items_done, loads_done, fetches_done, rail_writes);
		$display({"checked %0d cipher results (%0d exhausted, %0d last),",
			" %0d input stall cycles, %0d errors"},
			results_seen, exh_seen, last_seen, stall_cycles, fail_cnt);
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rfe_pkg.sv
rtl/rfe_ram.sv
rtl/rail_fence_encipher_top.sv
test/tb_rail_fence_encipher_top.sv
